// ===== rtl/msaws_pkg.sv =====
// shared types and constants for the masked summed-area window sum block
// no dependencies

package msaws_pkg;

  localparam int SUM_W     = 32;
  localparam int CNT_W     = 17;
  localparam int DIM_W     = 9;
  localparam int RAD_W     = 8;
  localparam int QPOS_W    = 8;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [DIM_W-1:0] GRID_ROWS_RESET     = 9'd256;
  localparam logic [DIM_W-1:0] GRID_COLS_RESET     = 9'd256;
  localparam logic [RAD_W-1:0] WINDOW_RADIUS_RESET = 8'd1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_OUTSIDE    = 2'd1,
    STAT_NOT_LOADED = 2'd2
  } status_t;

  // one prefix table entry, both sums kept modulo their output widths
  typedef struct packed {
    logic [SUM_W-1:0] val;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] box_sum;
    logic [CNT_W-1:0] valid_count;
    status_t          status;
  } result_t;

endpackage

// ===== rtl/msaws_mem.sv =====
// prefix table memory: one write port, one registered read port
// depends on msaws_pkg for the entry type

module msaws_mem
  import msaws_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/msaws_out.sv =====
// result output register between the sequencer and the master-side stream
// depends on msaws_pkg for the result type

module msaws_out
  import msaws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    valid_r;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/msaws_seq.sv =====
// load and query sequencer: config registers, load counters, prefix build,
// four-lookup window combine; depends on msaws_pkg, drives msaws_mem

module msaws_seq
  import msaws_pkg::*;
#(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [REG_IDX_W-1:0]   cfg_addr,
  input  logic [DIM_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [SAMPLE_BITS-1:0] in_value,
  input  logic                   in_svalid,
  input  logic [QPOS_W-1:0]      in_qrow,
  input  logic [QPOS_W-1:0]      in_qcol,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  entry_t                 mem_rd_data,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output entry_t                 mem_wr_data,
  output logic                   res_valid,
  output result_t                res,
  input  logic                   res_ready
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LD_WR = 7'b0000010,
    ST_Q_RD0 = 7'b0000100,
    ST_Q_RD1 = 7'b0001000,
    ST_Q_RD2 = 7'b0010000,
    ST_Q_RD3 = 7'b0100000,
    ST_Q_FIN = 7'b1000000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CLW-1:0] c);
    return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  state_t           state_r;
  logic [DIM_W-1:0] rows_r;
  logic [DIM_W-1:0] cols_r;
  logic [RAD_W-1:0] rad_r;
  logic [RW-1:0]    load_row_r;
  logic [CLW-1:0]   load_col_r;
  logic [SUM_W-1:0] row_val_r;
  logic [CNT_W-1:0] row_cnt_r;
  logic             grid_done_r;
  logic             above_z_r;
  status_t          status_r;
  logic [RW-1:0]    qr1_r;
  logic [RW-1:0]    qrm_r;
  logic [CLW-1:0]   qc1_r;
  logic [CLW-1:0]   qcm_r;
  logic             r0z_r;
  logic             c0z_r;
  logic [SUM_W-1:0] acc_val_r;
  logic [CNT_W-1:0] acc_cnt_r;

  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic             accept;
  logic             restart;
  logic [RW-1:0]    row_ld;
  logic [CLW-1:0]   col_ld;
  logic [SUM_W-1:0] sample_ext;
  logic             col_last;
  logic             row_last;
  status_t          q_status;
  logic [QPOS_W-1:0] r0;
  logic [QPOS_W-1:0] c0;
  logic [DIM_W-1:0] r1_raw;
  logic [DIM_W-1:0] c1_raw;
  logic [DIM_W-1:0] r1;
  logic [DIM_W-1:0] c1;
  logic [SUM_W-1:0] fin_val;
  logic [CNT_W-1:0] fin_cnt;

  assign rows_eff = (rows_r == '0) ? DIM_W'(1) :
                    (32'(rows_r) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
  assign cols_eff = (cols_r == '0) ? DIM_W'(1) :
                    (32'(cols_r) > 32'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // load path
  assign restart = grid_done_r || (32'(load_row_r) >= 32'(rows_eff)) ||
                   (32'(load_col_r) >= 32'(cols_eff));
  assign row_ld     = restart ? '0 : load_row_r;
  assign col_ld     = restart ? '0 : load_col_r;
  assign sample_ext = SUM_W'($signed(in_value));
  assign col_last   = (32'(load_col_r) + 32'd1) >= 32'(cols_eff);
  assign row_last   = (32'(load_row_r) + 32'd1) >= 32'(rows_eff);

  // query window bounds
  assign r0     = (in_qrow >= rad_r) ? (in_qrow - rad_r) : '0;
  assign c0     = (in_qcol >= rad_r) ? (in_qcol - rad_r) : '0;
  assign r1_raw = DIM_W'(in_qrow) + DIM_W'(rad_r);
  assign c1_raw = DIM_W'(in_qcol) + DIM_W'(rad_r);
  assign r1     = (r1_raw > rows_eff - DIM_W'(1)) ? rows_eff - DIM_W'(1) : r1_raw;
  assign c1     = (c1_raw > cols_eff - DIM_W'(1)) ? cols_eff - DIM_W'(1) : c1_raw;

  always_comb begin
    if (!grid_done_r) begin
      q_status = STAT_NOT_LOADED;
    end else if ((DIM_W'(in_qrow) >= rows_eff) || (DIM_W'(in_qcol) >= cols_eff)) begin
      q_status = STAT_OUTSIDE;
    end else begin
      q_status = STAT_OK;
    end
  end

  // memory requests
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = cell_addr(RW'(row_ld - RW'(1)), col_ld);
    unique case (state_r) inside
      ST_IDLE: begin
        mem_rd_en = accept && (in_mode == MODE_LOAD) && (row_ld != '0);
      end
      ST_Q_RD0: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cell_addr(qr1_r, qc1_r);
      end
      ST_Q_RD1: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cell_addr(qrm_r, qc1_r);
      end
      ST_Q_RD2: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cell_addr(qr1_r, qcm_r);
      end
      ST_Q_RD3: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cell_addr(qrm_r, qcm_r);
      end
      ST_LD_WR, ST_Q_FIN: begin
        mem_rd_en = 1'b0;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  assign mem_wr_en       = (state_r == ST_LD_WR);
  assign mem_wr_addr     = cell_addr(load_row_r, load_col_r);
  assign mem_wr_data.val = row_val_r + (above_z_r ? '0 : mem_rd_data.val);
  assign mem_wr_data.cnt = row_cnt_r + (above_z_r ? '0 : mem_rd_data.cnt);

  // final corner of the window
  assign fin_val = acc_val_r + ((r0z_r || c0z_r) ? '0 : mem_rd_data.val);
  assign fin_cnt = acc_cnt_r + ((r0z_r || c0z_r) ? '0 : mem_rd_data.cnt);

  assign res_valid = (state_r == ST_Q_FIN);
  always_comb begin
    res.status = status_r;
    if (status_r == STAT_OK) begin
      res.box_sum     = fin_val;
      res.valid_count = fin_cnt;
    end else begin
      res.box_sum     = '0;
      res.valid_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= GRID_ROWS_RESET;
      cols_r      <= GRID_COLS_RESET;
      rad_r       <= WINDOW_RADIUS_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      row_val_r   <= '0;
      row_cnt_r   <= '0;
      grid_done_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr) inside
        REG_GRID_ROWS, REG_GRID_COLS: begin
          if (cfg_addr == REG_GRID_ROWS) begin
            rows_r <= cfg_wdata;
          end else begin
            cols_r <= cfg_wdata;
          end
          load_row_r  <= '0;
          load_col_r  <= '0;
          row_val_r   <= '0;
          row_cnt_r   <= '0;
          grid_done_r <= 1'b0;
        end
        REG_WINDOW_RADIUS: begin
          rad_r <= cfg_wdata[RAD_W-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_mode == MODE_LOAD)) begin
            load_row_r  <= row_ld;
            load_col_r  <= col_ld;
            row_val_r   <= (restart ? '0 : row_val_r) + (in_svalid ? sample_ext : '0);
            row_cnt_r   <= (restart ? '0 : row_cnt_r) + CNT_W'(in_svalid);
            grid_done_r <= 1'b0;
            state_r     <= ST_LD_WR;
          end else if (accept) begin
            state_r <= (q_status == STAT_OK) ? ST_Q_RD0 : ST_Q_FIN;
          end
        end
        ST_LD_WR: begin
          if (col_last) begin
            load_col_r <= '0;
            row_val_r  <= '0;
            row_cnt_r  <= '0;
            if (row_last) begin
              load_row_r  <= '0;
              grid_done_r <= 1'b1;
            end else begin
              load_row_r <= load_row_r + RW'(1);
            end
          end else begin
            load_col_r <= load_col_r + CLW'(1);
          end
          state_r <= ST_IDLE;
        end
        ST_Q_RD0: state_r <= ST_Q_RD1;
        ST_Q_RD1: state_r <= ST_Q_RD2;
        ST_Q_RD2: state_r <= ST_Q_RD3;
        ST_Q_RD3: state_r <= ST_Q_FIN;
        ST_Q_FIN: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // query datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      above_z_r <= (row_ld == '0);
      status_r  <= q_status;
      qr1_r     <= RW'(r1);
      qc1_r     <= CLW'(c1);
      qrm_r     <= RW'(r0 - QPOS_W'(1));
      qcm_r     <= CLW'(c0 - QPOS_W'(1));
      r0z_r     <= (r0 == '0);
      c0z_r     <= (c0 == '0);
    end
    case (state_r)
      ST_Q_RD1: begin
        acc_val_r <= mem_rd_data.val;
        acc_cnt_r <= mem_rd_data.cnt;
      end
      ST_Q_RD2, ST_Q_RD3: begin
        if (!((state_r == ST_Q_RD2) ? r0z_r : c0z_r)) begin
          acc_val_r <= acc_val_r - mem_rd_data.val;
          acc_cnt_r <= acc_cnt_r - mem_rd_data.cnt;
        end
      end
      default: begin
      end
    endcase
  end

  a_wr_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !mem_rd_en && (state_r == ST_LD_WR))
    else $error("table write outside load write cycle");

  a_load_goes_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_LOAD && !cfg_wr_en) |=> (state_r == ST_LD_WR))
    else $error("load beat not followed by table write");

  a_done_counters_zero: assert property (@(posedge clk) disable iff (!rst_n)
    grid_done_r |-> (load_row_r == '0) && (load_col_r == '0))
    else $error("complete grid with nonzero load position");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready && !cfg_wr_en) |=> res_valid && $stable(status_r))
    else $error("stalled result dropped");

endmodule

// ===== rtl/masked_summed_area_window_sum.sv =====
// load: each sample beat reads the entry above, then writes back; no new beat is taken until the write
// query: four lookups through the single read port of the prefix memory, then the result
// waits for the output register; the next beat is taken once the result is accepted
// query answered by status alone: the lookups are skipped
// reset: config registers to defaults, load position and sums cleared,
// prefix memory not cleared (queries only read entries of a complete grid)

module masked_summed_area_window_sum
  import msaws_pkg::*;
#(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [DIM_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_value, sample_valid, query_row, query_col
  input  logic [((SAMPLE_BITS+1+2*QPOS_W+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // box sum, valid_count
  output logic [((SUM_W+CNT_W+7)/8)*8-1:0] out_tdata,
  // status
  output logic [1:0]            out_tuser
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int OUT_W  = ((SUM_W + CNT_W + 7) / 8) * 8;
  localparam int VLD_LO = SAMPLE_BITS;
  localparam int QR_LO  = SAMPLE_BITS + 1;
  localparam int QC_LO  = SAMPLE_BITS + 1 + QPOS_W;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  msaws_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  msaws_seq #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser[0]),
    .in_value    (in_tdata[SAMPLE_BITS-1:0]),
    .in_svalid   (in_tdata[VLD_LO]),
    .in_qrow     (in_tdata[QR_LO +: QPOS_W]),
    .in_qcol     (in_tdata[QC_LO +: QPOS_W]),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  msaws_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = OUT_W'({out_res.valid_count, out_res.box_sum});
  assign out_tuser = out_res.status;

endmodule

// ===== sim/masked_summed_area_window_sum_test.sv =====
// self-checking testbench for masked_summed_area_window_sum: loads grids, queries windows
// and checks every result beat against an in-bench summed-area predictor
// depends on rtl/msaws_pkg.sv and rtl/masked_summed_area_window_sum.sv

module masked_summed_area_window_sum_test;
  import msaws_pkg::*;

  localparam int GRID_MAX        = 256;
  localparam int SAMPLE_W        = 16;
  localparam int IN_W            = ((SAMPLE_W + 1 + 2 * QPOS_W + 7) / 8) * 8;
  localparam int OUT_W           = ((SUM_W + CNT_W + 7) / 8) * 8;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TOTAL_BEATS     = 1425;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic                mode;
    logic [SAMPLE_W-1:0] value;
    logic                valid;
    logic [QPOS_W-1:0]   qrow;
    logic [QPOS_W-1:0]   qcol;
  } beat_t;

  class box_scoreboard;
    int      rows;
    int      cols;
    int      radius;
    longint  value_tab[GRID_MAX*GRID_MAX];
    int      count_tab[GRID_MAX*GRID_MAX];
    longint  row_value;
    int      row_count;
    int      load_row;
    int      load_col;
    bit      complete;
    result_t windows_due[$];
    int      mismatches;

    function new();
      rows       = dim_used(GRID_ROWS_RESET);
      cols       = dim_used(GRID_COLS_RESET);
      radius     = WINDOW_RADIUS_RESET;
      mismatches = 0;
      restart_grid();
    endfunction

    function int dim_used(int v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void restart_grid();
      row_value = 0;
      row_count = 0;
      load_row  = 0;
      load_col  = 0;
      complete  = 1'b0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_GRID_ROWS: begin
          rows = dim_used(data);
          restart_grid();
        end
        REG_GRID_COLS: begin
          cols = dim_used(data);
          restart_grid();
        end
        REG_WINDOW_RADIUS: radius = data[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // prefix entry with an implicit zero row and column before the grid
    function void corner(int r, int c, output longint v, output int n);
      if (r < 0 || c < 0) begin
        v = 0;
        n = 0;
      end else begin
        v = value_tab[r*GRID_MAX + c];
        n = count_tab[r*GRID_MAX + c];
      end
    endfunction

    function void apply_beat(beat_t b);
      int      idx;
      int      qr;
      int      qc;
      int      r0;
      int      r1;
      int      c0;
      int      c1;
      longint  va;
      longint  vb;
      longint  vc;
      longint  vd;
      int      na;
      int      nb;
      int      nc;
      int      nd;
      longint  s;
      int      n;
      result_t res;
      if (b.mode == MODE_LOAD) begin
        if (complete || load_row >= rows || load_col >= cols) restart_grid();
        if (b.valid) begin
          row_value += longint'($signed(b.value));
          row_count++;
        end
        idx = load_row*GRID_MAX + load_col;
        value_tab[idx] = row_value + (load_row > 0 ? value_tab[idx-GRID_MAX] : 0);
        count_tab[idx] = row_count + (load_row > 0 ? count_tab[idx-GRID_MAX] : 0);
        load_col++;
        if (load_col >= cols) begin
          load_col  = 0;
          row_value = 0;
          row_count = 0;
          load_row++;
          if (load_row >= rows) begin
            load_row = 0;
            complete = 1'b1;
          end
        end
      end else begin
        res = '0;
        qr  = b.qrow;
        qc  = b.qcol;
        if (!complete) begin
          res.status = STAT_NOT_LOADED;
        end else if (qr >= rows || qc >= cols) begin
          res.status = STAT_OUTSIDE;
        end else begin
          r0 = (qr - radius < 0) ? 0 : qr - radius;
          c0 = (qc - radius < 0) ? 0 : qc - radius;
          r1 = (qr + radius > rows - 1) ? rows - 1 : qr + radius;
          c1 = (qc + radius > cols - 1) ? cols - 1 : qc + radius;
          corner(r1, c1, va, na);
          corner(r0 - 1, c1, vb, nb);
          corner(r1, c0 - 1, vc, nc);
          corner(r0 - 1, c0 - 1, vd, nd);
          s = va - vb - vc + vd;
          n = na - nb - nc + nd;
          res.box_sum     = s[SUM_W-1:0];
          res.valid_count = n[CNT_W-1:0];
          res.status      = STAT_OK;
        end
        windows_due = {windows_due, res};
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_window_result(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] cnt, logic [1:0] st);
      result_t due;
      if (windows_due.size() == 0) begin
        report_mismatch("result beat with no query waiting");
        return;
      end
      due = windows_due.pop_front();
      if (sum !== due.box_sum)
        report_mismatch($sformatf("box sum %0d, expected %0d", $signed(sum),
                                  $signed(due.box_sum)));
      if (cnt !== due.valid_count)
        report_mismatch($sformatf("valid_count %0d, expected %0d", cnt, due.valid_count));
      if (st !== due.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, due.status));
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr   = '0;
  logic [DIM_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic [1:0]           out_tuser;

  box_scoreboard sb = new();

  int send_idle    = 0;
  int recv_stall   = 0;
  int hold_off     = 0;
  int beats_sent   = 0;
  int stall_cycles = 0;

  masked_summed_area_window_sum u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_window_result(out_tdata[SUM_W-1:0], out_tdata[SUM_W+CNT_W-1:SUM_W], out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("masked_summed_area_window_sum_test failed");
        $finish;
      end
    end
  end

  task automatic send_beat(beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = b.mode;
    in_tdata  = IN_W'({b.qcol, b.qrow, b.valid, b.value});
    do @(posedge clk); while (!in_tready);
    sb.apply_beat(b);
    beats_sent++;
  endtask

  task automatic load_sample(logic [SAMPLE_W-1:0] v, logic valid);
    beat_t b;
    b.mode  = MODE_LOAD;
    b.value = v;
    b.valid = valid;
    b.qrow  = QPOS_W'($urandom);
    b.qcol  = QPOS_W'($urandom);
    send_beat(b);
  endtask

  task automatic query_cell(int r, int c);
    beat_t b;
    b.mode  = MODE_QUERY;
    b.value = SAMPLE_W'($urandom);
    b.valid = 1'($urandom);
    b.qrow  = QPOS_W'(r);
    b.qcol  = QPOS_W'(c);
    send_beat(b);
  endtask

  // idle the input, let every result come back, then give loads time to finish
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.windows_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    drain_pipeline();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_cells(int n);
    int                  i;
    logic [SAMPLE_W-1:0] v;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) query_cell($urandom_range(255), $urandom_range(255));
      case ($urandom_range(7))
        0:       v = 16'h8000;
        1:       v = 16'h7fff;
        default: v = SAMPLE_W'($urandom);
      endcase
      load_sample(v, $urandom_range(9) < 8);
    end
  endtask

  task automatic query_burst(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0)
        query_cell($urandom_range(255), $urandom_range(255));
      else
        query_cell($urandom_range(sb.rows - 1), $urandom_range(sb.cols - 1));
    end
  endtask

  initial begin
    int phase;
    int rows;
    int cols;
    int total;
    int rad;
    int send_pct[4];
    int stall_pct[4];
    send_pct  = '{0, 57, 0, 6};
    stall_pct = '{0, 0, 57, 6};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: corners of the fields and the status cases
    query_cell(255, 255);
    write_register(REG_UNUSED, 9'h1ff);
    write_register(REG_GRID_ROWS, 9'd0);
    write_register(REG_GRID_COLS, 9'd0);
    load_sample(16'h8000, 1'b1);
    query_cell(0, 0);
    query_cell(0, 1);
    query_cell(1, 0);
    load_sample(16'h7fff, 1'b1);
    query_cell(0, 0);
    load_sample(16'h1234, 1'b0);
    query_cell(0, 0);
    write_register(REG_GRID_ROWS, 9'd2);
    write_register(REG_GRID_COLS, 9'd3);
    write_register(REG_WINDOW_RADIUS, 9'd0);
    query_cell(200, 200);
    load_sample(16'h7fff, 1'b1);
    load_sample(16'h8000, 1'b1);
    load_sample(16'h0001, 1'b0);
    load_sample(16'hffff, 1'b1);
    load_sample(16'h5555, 1'b1);
    load_sample(16'haaaa, 1'b1);
    query_cell(1, 2);
    write_register(REG_WINDOW_RADIUS, 9'h1ff);
    query_cell(0, 0);
    query_cell(1, 1);
    write_register(REG_GRID_COLS, 9'd3);
    query_cell(1, 1);

    // random phases over grid shapes, radii and idling patterns
    for (phase = 0; beats_sent < TOTAL_BEATS; phase++) begin
      send_idle  = send_pct[phase % 4];
      recv_stall = stall_pct[phase % 4];
      case (phase)
        0: begin
          rows = 511;
          cols = 1;
        end
        1: begin
          rows = 1;
          cols = 256;
        end
        default: begin
          rows = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10);
          cols = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10);
        end
      endcase
      case ($urandom_range(5))
        0:       rad = 0;
        1:       rad = 1;
        2:       rad = $urandom_range(2, 4);
        3:       rad = 255;
        4:       rad = $urandom_range(255);
        default: rad = $urandom_range(1, 3);
      endcase
      if ($urandom_range(1))
        write_register(REG_WINDOW_RADIUS, {1'($urandom), 8'(rad)});
      write_register(REG_GRID_ROWS, DIM_W'(rows));
      write_register(REG_GRID_COLS, DIM_W'(cols));
      write_register(REG_WINDOW_RADIUS, {1'($urandom), 8'(rad)});
      total = sb.rows * sb.cols;

      if (phase >= 2 && phase % 4 != 2 && $urandom_range(9) == 0) begin
        load_cells($urandom_range(total - 1));
        query_burst(4);
      end else begin
        load_cells(total);
        if (phase % 4 == 2) begin
          @(posedge clk);
          hold_off = HOLD_OFF_CYCLES;
        end
        query_burst($urandom_range(10, 30));
        if ($urandom_range(1)) begin
          write_register(REG_WINDOW_RADIUS, DIM_W'($urandom_range(511)));
          query_burst(10);
        end
        if (total < 200 && $urandom_range(9) < 3) begin
          load_cells(total);
          query_burst(10);
        end
      end
    end

    drain_pipeline();
    if (sb.mismatches == 0)
      $display("masked_summed_area_window_sum_test passed");
    else
      $display("masked_summed_area_window_sum_test failed");
    $finish;
  end

endmodule
